/* src/pvr_pkg.sv */
// pvr_pkg: shared types and constants for the polar vector register unit
// holds the cordic stage record, mode codes, gain and arctangent table
// no dependencies
`timescale 1ns / 1ps

package pvr_pkg;

  // field widths
  localparam int COORD_W = 16;
  localparam int ANGLE_W = 16;

  // cordic sizing
  localparam int ITERS = 28;
  localparam int GUARD = 28;
  localparam int DW    = 48;
  localparam int ZW    = 34;
  localparam int CW    = DW - GUARD;
  localparam int SQ_W  = 2 * CW + 2;
  localparam int ROOT_W = SQ_W / 2;

  // cordic gain compensation, 2^30 scale
  localparam logic [29:0] KGAIN = 30'd652032874;

  // arctangent of 2^-i, 2^32 per turn
  localparam logic [31:0] ATAN_TAB [ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005
  };

  // operation codes
  typedef enum logic [2:0] {
    MODE_LOAD_CART  = 3'd0,
    MODE_LOAD_POLAR = 3'd1,
    MODE_ROTATE     = 3'd2,
    MODE_NEG_X      = 3'd3,
    MODE_NEG_Y      = 3'd4
  } mode_t;

  // record handed from one cordic cell to the next
  typedef struct packed {
    logic                 vld;
    logic                 vec;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

endpackage

/* src/pvr_cordic_cell.sv */
// pvr_cordic_cell: one registered cordic iteration, rotation or vectoring
// depends on pvr_pkg
`timescale 1ns / 1ps

module pvr_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  pvr_pkg::cordic_t din,
  output pvr_pkg::cordic_t dout
);
  import pvr_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = ZW'(ATAN_TAB[STAGE]);

  logic                 plus;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;

  // direction: rotation follows sign of z, vectoring drives y toward zero
  always_comb begin
    dx   = $signed(din.y) >>> STAGE;
    dy   = $signed(din.x) >>> STAGE;
    plus = din.vec ? (din.y[DW-1] || (din.y == '0)) : !din.z[ZW-1];
  end

  // valid travels with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
  end

  // micro-rotation
  always_ff @(posedge clk) begin
    dout.vec <= din.vec;
    if (plus) begin
      dout.x <= $signed(din.x) - dx;
      dout.y <= $signed(din.y) + dy;
      dout.z <= $signed(din.z) - ATAN;
    end else begin
      dout.x <= $signed(din.x) + dx;
      dout.y <= $signed(din.y) - dy;
      dout.z <= $signed(din.z) + ATAN;
    end
  end

endmodule

/* src/pvr_isqrt.sv */
// pvr_isqrt: bit-serial square root, two radicand bits per cycle while busy, rounded
// depends on pvr_pkg
`timescale 1ns / 1ps

module pvr_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pvr_pkg::SQ_W-1:0]    radicand,
  output logic                        busy,
  output logic [pvr_pkg::COORD_W-1:0] root
);
  import pvr_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W + 1);
  localparam logic [ROOT_W:0] CLIP = (ROOT_W + 1)'(2 ** COORD_W - 1);

  logic [SQ_W-1:0]   val;
  logic [ROOT_W+1:0] rem;
  logic [ROOT_W-1:0] acc;
  logic [CNT_W-1:0]  cnt;

  logic [ROOT_W+3:0] rem_t;
  logic [ROOT_W+3:0] trial;
  logic [ROOT_W:0]   rnd;

  // trial subtract for the next root bit
  always_comb begin
    rem_t = {rem, val[SQ_W-1 -: 2]};
    trial = (ROOT_W + 4)'({acc, 2'b01});
    rnd   = ((ROOT_W + 2)'(rem) > (ROOT_W + 2)'(acc)) ?
            (ROOT_W + 1)'(acc) + (ROOT_W + 1)'(1) : (ROOT_W + 1)'(acc);
    root  = (rnd > CLIP) ? COORD_W'(CLIP) : COORD_W'(rnd);
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(ROOT_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // root and remainder
  always_ff @(posedge clk) begin
    if (start) begin
      val <= radicand;
      rem <= '0;
      acc <= '0;
    end else if (busy) begin
      val <= val << 2;
      if (rem_t >= trial) begin
        rem <= (ROOT_W + 2)'(rem_t - trial);
        acc <= {acc[ROOT_W-2:0], 1'b1};
      end else begin
        rem <= (ROOT_W + 2)'(rem_t);
        acc <= {acc[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

/* src/polar_vector_register_unit.sv */
// polar_vector_register_unit: polar vector register with a row of cordic cells
// depends on pvr_pkg, pvr_cordic_cell, pvr_isqrt
//
// channel | signals                  | contents
// input   | s_tvalid s_tready s_tdata | mode, x_in, y_in, angle_in, magnitude_in
// output  | m_tvalid m_tready m_tdata | angle_out, magnitude_out, x_out, y_out
//         | m_tuser                   | saturated
//
// each pass goes once through the 28-cell cordic row; one item in flight
// load polar, rotate and unused modes: one rotation pass; the next input transfer is taken
// once the result is registered
// load cartesian: vectoring with square root, then rotation
// reflect x or y: rotation, vectoring, rotation
// rst is synchronous and clears the stored vector to zero angle and length
// a waiting result sits in the output register while the next item is taken; the final
// rotation pass starts only once that register is free, so output stalls delay the result
`timescale 1ns / 1ps

module polar_vector_register_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // mode[2:0], x_in[18:3], y_in[34:19], angle_in[50:35], magnitude_in[65:51], zero pad
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // angle_out[15:0], magnitude_out[31:16], x_out[47:32], y_out[63:48]
  output logic [63:0] m_tdata,
  // saturated[0]
  output logic [0:0]  m_tuser
);
  import pvr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_PREP    = 7'b0000010,
    S_ROTFEED = 7'b0000100,
    S_ROTWAIT = 7'b0001000,
    S_SQUARE  = 7'b0010000,
    S_VECFEED = 7'b0100000,
    S_VECWAIT = 7'b1000000
  } state_t;

  localparam logic [ANGLE_W-1:0] HALF    = ANGLE_W'(1) << (ANGLE_W - 1);
  localparam logic [ANGLE_W-1:0] QUARTER = ANGLE_W'(1) << (ANGLE_W - 2);
  localparam logic signed [CW-1:0] SMAX = CW'(2 ** (COORD_W - 1) - 1);
  localparam logic signed [CW-1:0] SMIN = -SMAX - CW'(1);
  localparam int ASHIFT = 32 - ANGLE_W;

  state_t               state;
  mode_t                mode_q;
  logic                 final_pass;
  logic [ANGLE_W-1:0]   angle_store;
  logic [COORD_W-1:0]   magnitude_store;
  logic signed [CW-1:0] op_x;
  logic signed [CW-1:0] op_y;
  logic [2*CW-1:0]      sq_x;
  logic [2*CW-1:0]      sq_y;
  logic [DW-1:0]        kx;

  // input fields
  logic [2:0]           in_mode;
  logic [COORD_W-1:0]   in_x;
  logic [COORD_W-1:0]   in_y;
  logic [ANGLE_W-1:0]   in_angle;
  logic [COORD_W-2:0]   in_mag;
  logic                 in_xfer;

  logic [CW-1:0]        ax;
  logic [CW-1:0]        ay;
  logic                 feed_ok;
  cordic_t              feed;
  cordic_t              stage_d [ITERS+1];
  cordic_t              chain_out;

  logic                 sq_start;
  logic                 sq_busy;
  logic [COORD_W-1:0]   sq_root;

  logic [DW-1:0]        rsum_x;
  logic [DW-1:0]        rsum_y;
  logic signed [CW-1:0] rx;
  logic signed [CW-1:0] ry;
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic [COORD_W-1:0]   x_sat;
  logic [COORD_W-1:0]   y_sat;
  logic                 sat;
  logic [ZW-1:0]        zc;
  logic [ZW-1:0]        tsum;
  logic [ANGLE_W-1:0]   t;
  logic [ANGLE_W-1:0]   ang;

  // unpack input transfer
  always_comb begin
    in_mode  = s_tdata[2:0];
    in_x     = s_tdata[18:3];
    in_y     = s_tdata[34:19];
    in_angle = s_tdata[50:35];
    in_mag   = s_tdata[65:51];
    s_tready = (state == S_IDLE);
    in_xfer  = s_tvalid && s_tready;
  end

  // absolute operands
  always_comb begin
    ax = op_x[CW-1] ? CW'(-op_x) : CW'(op_x);
    ay = op_y[CW-1] ? CW'(-op_y) : CW'(op_y);
  end

  // cordic feed: rotation from the stored vector, vectoring from the operands
  always_comb begin
    feed_ok  = !final_pass || !m_tvalid || m_tready;
    sq_start = (state == S_VECFEED);
    feed.vld = ((state == S_ROTFEED) && feed_ok) || (state == S_VECFEED);
    feed.vec = (state == S_VECFEED);
    if (state == S_VECFEED) begin
      feed.x = $signed({ax, GUARD'(0)});
      feed.y = $signed({ay, GUARD'(0)});
      feed.z = '0;
    end else begin
      feed.x = $signed(kx);
      feed.y = '0;
      feed.z = $signed(ZW'({angle_store[ANGLE_W-3:0], ASHIFT'(0)}));
    end
  end

  // row of cordic cells
  assign stage_d[0] = feed;
  for (genvar g = 0; g < ITERS; g++) begin : g_cell
    pvr_cordic_cell #(.STAGE(g)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (stage_d[g]),
      .dout (stage_d[g+1])
    );
  end
  assign chain_out = stage_d[ITERS];

  // square root of the squared length
  pvr_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (SQ_W'(sq_x) + SQ_W'(sq_y)),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  // rotation result: round to q8.8, turn into the quadrant, saturate
  always_comb begin
    rsum_x = chain_out.x + (DW'(1) << (GUARD - 1));
    rsum_y = chain_out.y + (DW'(1) << (GUARD - 1));
    rx     = $signed(rsum_x[DW-1:GUARD]);
    ry     = $signed(rsum_y[DW-1:GUARD]);
    case (angle_store[ANGLE_W-1 -: 2])
      2'd0:    begin cx = rx;  cy = ry;  end
      2'd1:    begin cx = -ry; cy = rx;  end
      2'd2:    begin cx = -rx; cy = -ry; end
      default: begin cx = ry;  cy = -rx; end
    endcase
    sat = 1'b0;
    if (cx > SMAX) begin
      x_sat = COORD_W'(SMAX);
      sat   = 1'b1;
    end else if (cx < SMIN) begin
      x_sat = COORD_W'(SMIN);
      sat   = 1'b1;
    end else begin
      x_sat = COORD_W'(cx);
    end
    if (cy > SMAX) begin
      y_sat = COORD_W'(SMAX);
      sat   = 1'b1;
    end else if (cy < SMIN) begin
      y_sat = COORD_W'(SMIN);
      sat   = 1'b1;
    end else begin
      y_sat = COORD_W'(cy);
    end
  end

  // vectoring result: round the angle, resolve axes and quadrant
  always_comb begin
    zc   = chain_out.z[ZW-1] ? '0 : chain_out.z;
    tsum = zc + (ZW'(1) << (ASHIFT - 1));
    t    = tsum[ANGLE_W+ASHIFT-1:ASHIFT];
    if (op_x == '0) begin
      if (op_y == '0) begin
        ang = '0;
      end else if (!op_y[CW-1]) begin
        ang = QUARTER;
      end else begin
        ang = HALF + QUARTER;
      end
    end else if (op_y == '0) begin
      ang = op_x[CW-1] ? HALF : '0;
    end else if (!op_x[CW-1] && !op_y[CW-1]) begin
      ang = t;
    end else if (!op_x[CW-1]) begin
      ang = ANGLE_W'(0) - t;
    end else if (!op_y[CW-1]) begin
      ang = HALF - t;
    end else begin
      ang = HALF + t;
    end
  end

  // sequencer, stored vector and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      final_pass      <= 1'b0;
      angle_store     <= '0;
      magnitude_store <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            case (in_mode) inside
              MODE_LOAD_CART: begin
                final_pass <= 1'b0;
                state      <= S_SQUARE;
              end
              MODE_LOAD_POLAR: begin
                angle_store     <= in_angle;
                magnitude_store <= COORD_W'(in_mag);
                final_pass      <= 1'b1;
                state           <= S_PREP;
              end
              MODE_ROTATE: begin
                angle_store <= angle_store + in_angle;
                final_pass  <= 1'b1;
                state       <= S_PREP;
              end
              MODE_NEG_X, MODE_NEG_Y: begin
                final_pass <= 1'b0;
                state      <= S_PREP;
              end
              default: begin
                final_pass <= 1'b1;
                state      <= S_PREP;
              end
            endcase
          end
        end
        S_PREP: begin
          state <= S_ROTFEED;
        end
        S_ROTFEED: begin
          if (feed_ok) begin
            state <= S_ROTWAIT;
          end
        end
        S_ROTWAIT: begin
          if (chain_out.vld) begin
            if (final_pass) begin
              m_tvalid <= 1'b1;
              state    <= S_IDLE;
            end else begin
              state <= S_SQUARE;
            end
          end
        end
        S_SQUARE: begin
          state <= S_VECFEED;
        end
        S_VECFEED: begin
          state <= S_VECWAIT;
        end
        S_VECWAIT: begin
          if (chain_out.vld) begin
            angle_store     <= ang;
            magnitude_store <= sq_root;
            final_pass      <= 1'b1;
            state           <= S_PREP;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // operands, squares, gain product and result payload
  always_ff @(posedge clk) begin
    kx   <= DW'(((2 * COORD_W + 14)'(magnitude_store) * (2 * COORD_W + 14)'(KGAIN)) >> 2);
    sq_x <= (2 * CW)'(ax) * (2 * CW)'(ax);
    sq_y <= (2 * CW)'(ay) * (2 * CW)'(ay);
    if (in_xfer) begin
      mode_q <= mode_t'(in_mode);
      op_x   <= CW'($signed(in_x));
      op_y   <= CW'($signed(in_y));
    end
    if ((state == S_ROTWAIT) && chain_out.vld) begin
      if (final_pass) begin
        m_tdata <= {y_sat, x_sat, magnitude_store, angle_store};
        m_tuser <= sat;
      end else if (mode_q == MODE_NEG_X) begin
        op_x <= -cx;
        op_y <= cy;
      end else begin
        op_x <= cx;
        op_y <= -cy;
      end
    end
  end

`ifndef SYNTHESIS
  // cordic results only arrive while a pass is awaited
  a_chain_expected: assert property (@(posedge clk) disable iff (rst)
    chain_out.vld |-> ((state == S_ROTWAIT) || (state == S_VECWAIT)))
    else $error("cordic result with no pass pending");

  // square root finishes by the end of the vectoring pass
  a_root_ready: assert property (@(posedge clk) disable iff (rst)
    ((state == S_VECWAIT) && chain_out.vld) |-> !sq_busy)
    else $error("square root still running at end of vectoring pass");

  // a new result never overwrites one that waits
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    ((state == S_ROTWAIT) && chain_out.vld && final_pass) |-> !m_tvalid)
    else $error("result register still occupied");

  // stored vector changes only on acceptance or at end of vectoring
  a_store_hold: assert property (@(posedge clk) disable iff (rst)
    ((state != S_IDLE) && (state != S_VECWAIT)) |=> $stable(magnitude_store))
    else $error("magnitude changed mid pass");
`endif

endmodule
